### sv/kci_pkg.sv
// Package for the keyframe colour interpolator: sizes, status codes, types.
// No dependencies.
`default_nettype none
package kci_pkg;
    localparam int MAX_FRAMES_DEF = 10;
    localparam int NUM_CLIPS_DEF  = 8;
    localparam int LEN_W   = 15;
    localparam int TOTAL_W = 19;
    localparam int TICK_W  = 24;
    localparam int COLOR_W = 32;
    localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        ST_EVAL    = 2'd0,
        ST_STORED  = 2'd1,
        ST_DROPPED = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;
endpackage
`default_nettype wire

### sv/kci_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module kci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 80
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### sv/kci_divider.sv
// Restoring divider, one quotient bit per cycle, shared for modulo and weight.
// Depends on nothing.
`default_nettype none
module kci_divider #(
    parameter int NW = 32,
    parameter int DW = 19
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic      [NW-1:0] quo,
    output logic      [DW-1:0] rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {r_reg, q_reg[NW-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                r_reg <= diff[DW-1:0];
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[DW-1:0];
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quo = q_reg;
    assign rem = r_reg;
endmodule
`default_nettype wire

### sv/keyframe_color_interpolator.sv
// Keyframe colour interpolator top level: clip tables, sequencer, blend.
// Depends on kci_pkg, kci_ram, kci_divider.
// The result of an evaluate on an empty or unknown clip is valid in the cycle after
// acceptance, that of a load after the S_LOAD state, and that of an evaluate after
// a pass through the shared bit-serial divider for tick modulo total when the tick
// exceeds the total, a walk through the length RAM (S_RD, S_CHK per frame), a second
// divider pass for the 17-bit weight, two colour reads and a blend. in_ready is low
// while a word is being worked on; the result sits in an output register until taken,
// and in_ready returns the cycle after.
`default_nettype none
module keyframe_color_interpolator #(
    parameter int MAX_FRAMES = kci_pkg::MAX_FRAMES_DEF,
    parameter int NUM_CLIPS  = kci_pkg::NUM_CLIPS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [2:0]  clip_index,
    input  wire logic [23:0] time_tick,
    input  wire logic signed [15:0] frame_duration,
    input  wire logic [7:0]  in_red,
    input  wire logic [7:0]  in_green,
    input  wire logic [7:0]  in_blue,
    input  wire logic [7:0]  in_alpha,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_alpha,
    output logic [1:0]       status
);
    localparam int SLOTS = NUM_CLIPS * MAX_FRAMES;
    localparam int AW    = $clog2(SLOTS);
    localparam int FW    = $clog2(MAX_FRAMES + 1);
    localparam int FIW   = $clog2(MAX_FRAMES);
    localparam int CIW   = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;
    localparam int LW    = kci_pkg::LEN_W;
    localparam int TW    = kci_pkg::TOTAL_W;
    localparam int NW    = 32;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_LOAD  = 12'b000000000010,
        S_MOD   = 12'b000000000100,
        S_MODW  = 12'b000000001000,
        S_RD    = 12'b000000010000,
        S_CHK   = 12'b000000100000,
        S_DIV   = 12'b000001000000,
        S_DIVW  = 12'b000010000000,
        S_CRL   = 12'b000100000000,
        S_CRR   = 12'b001000000000,
        S_MIX   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [FW-1:0] count_reg [NUM_CLIPS];
    logic [TW-1:0] total_reg [NUM_CLIPS];

    logic [CIW-1:0] clip_reg;
    logic          clip_ok_reg;
    logic [TW-1:0] t_reg;
    logic [23:0]   tick_reg;
    logic [LW-1:0] mag_reg;
    logic [31:0]   color_in_reg;
    logic [FW-1:0] n_reg;
    logic [FIW-1:0] i_reg, left_reg;
    logic          found_reg;
    logic [LW-1:0] d_reg;
    logic [16:0]   w_reg;
    logic [31:0]   cl_reg;
    logic [31:0]   res_reg;
    logic [1:0]    st_reg;

    logic [AW-1:0] base;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [LW-1:0] len_rd;
    logic [31:0]   col_rd;

    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [TW-1:0] div_den, div_rem;

    logic [15:0]   raw_mag;
    logic [LW-1:0] sat_mag;
    logic [TW:0]   tot_sum;

    logic          eval_ok;
    logic          walk_skip;
    logic          last_frame;

    assign base = AW'(clip_reg * MAX_FRAMES);

    assign raw_mag = frame_duration[15] ? 16'(-frame_duration) : frame_duration;
    assign sat_mag = raw_mag[15] ? kci_pkg::LEN_MAX : raw_mag[LW-1:0];
    assign tot_sum = {1'b0, total_reg[clip_reg]} + {{(TW+1-LW){1'b0}}, mag_reg};

    assign eval_ok    = (clip_index < NUM_CLIPS)
                        && count_reg[CIW'(clip_index)] != '0
                        && total_reg[CIW'(clip_index)] != '0;
    assign walk_skip  = (len_rd == '0) || ({{(TW-LW){1'b0}}, len_rd} < t_reg);
    assign last_frame = (FW'(i_reg) + FW'(1) >= n_reg);

    always_comb
    begin
        ram_we   = 1'b0;
        ram_addr = base + AW'(i_reg);
        case (state_reg)
            S_LOAD:
            begin
                ram_addr = base + AW'(count_reg[clip_reg]);
                ram_we   = clip_ok_reg && (count_reg[clip_reg] < FW'(MAX_FRAMES));
            end
            S_CRL, S_DIV, S_DIVW: ram_addr = base + AW'(left_reg);
            S_CRR:
            begin
                if ({{(32-FW){1'b0}}, FW'(left_reg) + FW'(1)} >= {{(32-FW){1'b0}}, n_reg})
                begin
                    ram_addr = base;
                end
                else
                begin
                    ram_addr = base + AW'(left_reg) + AW'(1);
                end
            end
            default: ram_addr = base + AW'(i_reg);
        endcase
    end

    kci_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_len (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(mag_reg), .rdata(len_rd)
    );
    kci_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_col (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(color_in_reg), .rdata(col_rd)
    );

    assign div_start = (state_reg == S_MOD) || (state_reg == S_DIV);
    assign div_num = (state_reg == S_MOD) ? NW'(tick_reg)
                                          : {{(NW-LW-16){1'b0}}, t_reg[LW-1:0], 16'h0};
    assign div_den = (state_reg == S_MOD) ? total_reg[clip_reg] : TW'(d_reg);

    kci_divider #(.NW(NW), .DW(TW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo), .rem(div_rem)
    );

    // Blend: one channel multiply pair per lane
    logic [16:0] wr;
    logic [31:0] mix;
    assign wr = 17'h10000 - w_reg;
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            mix[8*k +: 8] = 8'((({17'b0, cl_reg[8*k +: 8]} * {8'b0, wr})
                              + ({17'b0, col_rd[8*k +: 8]} * {8'b0, w_reg})
                              + 25'h8000) >> 16);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!mode)
                        state_next = S_LOAD;
                    else if (eval_ok)
                        state_next = S_MOD;
                    else
                        state_next = S_OUT;
                end
            end
            S_LOAD: state_next = S_OUT;
            S_MOD:  state_next = ({5'b0, t_reg} < tick_reg) ? S_MODW : S_RD;
            S_MODW: if (div_done) state_next = S_RD;
            S_RD:   state_next = S_CHK;
            S_CHK:  state_next = (!walk_skip || last_frame) ? S_DIV : S_RD;
            S_DIV:  state_next = S_DIVW;
            S_DIVW: if (div_done) state_next = S_CRL;
            S_CRL:  state_next = S_CRR;
            S_CRR:  state_next = S_MIX;
            S_MIX:  state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int c = 0; c < NUM_CLIPS; c++)
            begin
                count_reg[c] <= '0;
                total_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOAD && ram_we)
            begin
                count_reg[clip_reg] <= count_reg[clip_reg] + 1'b1;
                total_reg[clip_reg] <= tot_sum[TW] ? kci_pkg::TOTAL_MAX
                                                   : tot_sum[TW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                clip_reg     <= CIW'(clip_index);
                clip_ok_reg  <= (clip_index < NUM_CLIPS);
                tick_reg     <= time_tick;
                t_reg        <= (time_tick > 24'({5'b0, total_reg[CIW'(clip_index)]}))
                                ? TW'(0) : TW'(time_tick);
                mag_reg      <= sat_mag;
                color_in_reg <= {in_alpha, in_blue, in_green, in_red};
                n_reg        <= count_reg[CIW'(clip_index)];
                i_reg        <= '0;
                left_reg     <= '0;
                found_reg    <= 1'b0;
                res_reg      <= '0;
                if (!mode)
                begin
                    st_reg <= kci_pkg::ST_STORED;
                end
                else
                begin
                    st_reg <= kci_pkg::ST_EMPTY;
                end
            end
            S_LOAD:
            begin
                if (!ram_we)
                begin
                    st_reg <= kci_pkg::ST_DROPPED;
                end
            end
            S_MODW:
            begin
                if (div_done)
                begin
                    t_reg <= div_rem;
                end
            end
            S_CHK:
            begin
                st_reg <= kci_pkg::ST_EVAL;
                d_reg  <= len_rd;
                if (walk_skip)
                begin
                    if (len_rd != '0)
                    begin
                        t_reg <= t_reg - TW'(len_rd);
                    end
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    left_reg  <= i_reg;
                    found_reg <= 1'b1;
                end
            end
            S_DIV:
            begin
                if (!found_reg)
                begin
                    left_reg <= '0;
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    if (!found_reg || d_reg == '0 || div_quo > NW'(32'h10000))
                    begin
                        w_reg <= found_reg && d_reg != '0 ? 17'h10000 : 17'h0;
                    end
                    else
                    begin
                        w_reg <= div_quo[16:0];
                    end
                end
            end
            S_CRR: cl_reg <= col_rd;
            S_MIX: res_reg <= mix;
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_red   = res_reg[7:0];
    assign out_green = res_reg[15:8];
    assign out_blue  = res_reg[23:16];
    assign out_alpha = res_reg[31:24];
    assign status    = st_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("ready while result held");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_reg))
        else $error("result changed while stalled");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != kci_pkg::ST_EVAL |-> res_reg == '0)
        else $error("colour not zero on non-evaluate status");
`endif
endmodule
`default_nettype wire
